/* design/oal_pkg.sv */
// Shared types, command and status codes for the ordered array list engine.
package oal_pkg;

  // Store depth default
  localparam int DEPTH_DEF = 16;

  // Reset value of the capacity register
  localparam logic [4:0] CAP_RESET = 5'd16;

  // Command codes
  localparam logic [2:0] CMD_APPEND   = 3'd0;
  localparam logic [2:0] CMD_INSERT   = 3'd1;
  localparam logic [2:0] CMD_DEL_LAST = 3'd2;
  localparam logic [2:0] CMD_DEL_POS  = 3'd3;
  localparam logic [2:0] CMD_DUMP     = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Input request
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] data_word;
    logic [4:0]         position;
  } req_t;

  // Result
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_word;
    logic [3:0]         entry_index;
    logic [4:0]         item_count;
    logic               last_result;
  } rsp_t;

  // What every cell does this cycle
  typedef enum logic [2:0] {
    COP_HOLD,
    COP_APPEND,
    COP_INSERT,
    COP_DELETE,
    COP_ROTATE
  } cell_op_t;

  // Broadcast control to the cell row
  typedef struct packed {
    cell_op_t    op;
    logic [31:0] word;
  } cell_ctrl_t;

endpackage

/* design/oal_cell.sv */
// One list entry cell: holds a word and shifts with its neighbors.
module oal_cell import oal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] pos,
  input  logic [CW-1:0] count,
  input  logic [31:0]   left_word,
  input  logic [31:0]   right_word,
  input  logic [31:0]   head_word,
  output logic [31:0]   word_o
);

  localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
  localparam logic [CW:0] IDX_P1 = (CW+1)'(IDX + 1);

  logic [31:0] word_r, word_nxt;
  logic [CW:0] pos_w, cnt_w;

  assign pos_w = {1'b0, pos};
  assign cnt_w = {1'b0, count};

  // Next value from the broadcast command and this cell's place
  always_comb begin
    word_nxt = word_r;
    case (ctrl.op)
      COP_APPEND: begin
        if (IDX_W == cnt_w) word_nxt = ctrl.word;
      end
      COP_INSERT: begin
        if (IDX_W == pos_w) word_nxt = ctrl.word;
        else if (IDX_W > pos_w && IDX_W <= cnt_w) word_nxt = left_word;
      end
      COP_DELETE: begin
        if (IDX_W >= pos_w && IDX_P1 < cnt_w) word_nxt = right_word;
      end
      COP_ROTATE: begin
        if (IDX_P1 < cnt_w) word_nxt = right_word;
        else if (IDX_P1 == cnt_w) word_nxt = head_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

/* design/ordered_array_list_engine.sv */
// Top level: command decode, entry count, dump sequencer and the row of entry cells.
// Every request gives its first result in the cycle after it is accepted.
// Throughput: one request per cycle, except a dump of n entries, which keeps busy
//   high until its last entry has been read from the row and gives one result per cycle.
// Insert and delete at a position shift the cells from that position up together; dump rotates the row n times.
// Reset (synchronous, rst_n low) empties the list and sets capacity to 16; cell
//   contents are left as they are. The receiver cannot stall results.
module ordered_array_list_engine import oal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  req_t       in_req,
  output logic       out_valid,
  output rsp_t       out_rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_capacity
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int KW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [4:0]    cap_r;
  logic [KW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_r, out_nxt;

  cell_ctrl_t    ctrl;
  logic [31:0]   cell_word [DEPTH];

  logic            accept;
  logic [CMPW-1:0] cnt_ext, cap_ext, pos_ext, eff_cap, item_ext, k_ext;
  logic            full;

  assign accept  = start && (state_r == S_IDLE);
  assign cnt_ext = CMPW'(count_r);
  assign cap_ext = CMPW'(cap_r);
  assign pos_ext = CMPW'(in_req.position);
  assign eff_cap = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign full    = cnt_ext >= eff_cap;
  assign item_ext = CMPW'(count_nxt);
  assign k_ext   = CMPW'(k_r);

  // Command decode and dump sequencing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctrl.op       = COP_HOLD;
    ctrl.word     = in_req.data_word;
    if (state_r == S_DUMP) begin
      ctrl.op             = COP_ROTATE;
      out_valid_nxt       = 1'b1;
      out_nxt.status      = ST_OK;
      out_nxt.entry_word  = cell_word[0];
      out_nxt.entry_index = k_ext[3:0];
      out_nxt.last_result = (k_ext + CMPW'(1)) == cnt_ext;
      k_nxt               = k_r + KW'(1);
      if (out_nxt.last_result) state_nxt = S_IDLE;
    end else if (accept) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = ST_OK;
      out_nxt.entry_word  = '0;
      out_nxt.entry_index = '0;
      out_nxt.last_result = 1'b1;
      case (in_req.command)
        CMD_APPEND: begin
          if (full) out_nxt.status = ST_FULL;
          else begin
            ctrl.op   = COP_APPEND;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_INSERT: begin
          if (pos_ext > cnt_ext) out_nxt.status = ST_BADPOS;
          else if (full) out_nxt.status = ST_FULL;
          else begin
            ctrl.op   = COP_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_DEL_LAST: begin
          if (count_r == '0) out_nxt.status = ST_EMPTY;
          else count_nxt = count_r - CW'(1);
        end
        CMD_DEL_POS: begin
          if (count_r == '0) out_nxt.status = ST_EMPTY;
          else if (pos_ext >= cnt_ext) out_nxt.status = ST_BADPOS;
          else begin
            ctrl.op   = COP_DELETE;
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_DUMP: begin
          if (count_r == '0) out_nxt.status = ST_EMPTY;
          else begin
            // first entry goes out now, the row rotates by one
            ctrl.op             = COP_ROTATE;
            out_nxt.entry_word  = cell_word[0];
            out_nxt.last_result = (count_r == CW'(1));
            k_nxt               = KW'(1);
            if (!out_nxt.last_result) state_nxt = S_DUMP;
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
    out_nxt.item_count = item_ext[4:0];
  end

  // State, count, capacity and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cap_r <= cfg_capacity;
    end
    out_r <= out_nxt;
  end

  // Row of entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_li
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_ro
      assign right_w = '0;
    end else begin : g_ri
      assign right_w = cell_word[i+1];
    end
    oal_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (CW'(in_req.position)),
      .count      (count_r),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (cell_word[0]),
      .word_o     (cell_word[i])
    );
  end

  assign busy      = (state_r == S_DUMP);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

/* design/oal_checker.sv */
// Port-level checker for the ordered array list engine, bound to the top level.
module oal_checker import oal_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input rsp_t out_rsp
);

  // Every accepted request shows a result in the next cycle
  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after accepted request");

  // A running dump delivers one entry per cycle
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("dump stalled");

  // A result that is not the final one only appears while a dump is running
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.last_result) |-> busy)
    else $error("non-final result outside dump");

  // Error statuses are single, final results with zero entry fields
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_OK) |->
      (out_rsp.last_result && out_rsp.entry_word == '0 && out_rsp.entry_index == '0))
    else $error("malformed error result");

endmodule

bind ordered_array_list_engine oal_checker u_oal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
